/* design/lfu_replacement_list_macros.svh */
// Assertion macros shared by the LFU replacement list RTL.
// No dependencies; pulled in by the top level with an include.
`ifndef LFU_REPLACEMENT_LIST_MACROS_SVH
`define LFU_REPLACEMENT_LIST_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define LFU_ASSERT_IMPL(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lfu assertion failed");

// Next-cycle implication, checked out of reset.
`define LFU_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lfu assertion failed");

`endif

/* design/lfu_pkg.sv */
// Shared types and constants of the LFU replacement list.
// No dependencies; used by the interfaces, controller, datapath and top level.
`timescale 1ns / 1ps
`default_nettype none
package lfu_pkg;

   localparam int CAPACITY  = 16;
   localparam int ID_WIDTH  = 8;   // at most SKIN_ID_W
   localparam int USE_WIDTH = 16;
   localparam int SKIN_ID_W = 8;
   localparam int REQ_W     = 2;

   localparam int IDX_W = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);

   typedef logic [ID_WIDTH-1:0]  id_type;
   typedef logic [USE_WIDTH-1:0] use_type;
   typedef logic [IDX_W-1:0]     idx_type;
   typedef logic [CNT_W-1:0]     cnt_type;

   localparam use_type USE_MAX = {USE_WIDTH{1'b1}};

   typedef enum logic [REQ_W-1:0] {
      REQ_CLEAR = 2'd0,
      REQ_ADD   = 2'd1,
      REQ_USE   = 2'd2
   } req_code_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_REPORT
   } state_type;

   typedef struct packed {
      logic load_req;   // capture the request on this transfer
      logic exec;       // search and update the list
      logic load_rsp;   // load the result register
   } cmd_type;

   typedef struct packed {
      cnt_type count;   // entries held
   } status_type;

endpackage
`default_nettype wire

/* design/lfu_req_if.sv */
// Request channel of the LFU replacement list: valid/ready plus payload.
// Depends on lfu_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none
interface lfu_req_if;
   logic                                valid;
   logic                                ready;
   logic [lfu_pkg::REQ_W-1:0]           req_type;
   logic [lfu_pkg::SKIN_ID_W-1:0]       skin_id;

   modport source (output valid, req_type, skin_id, input ready);
   modport sink   (input valid, req_type, skin_id, output ready);
endinterface
`default_nettype wire

/* design/lfu_rsp_if.sv */
// Response channel of the LFU replacement list: valid/ready plus payload.
// Depends on lfu_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none
interface lfu_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          hit;
   logic                          dropped;
   logic                          victim_valid;
   logic [lfu_pkg::SKIN_ID_W-1:0] victim_id;

   modport source (output valid, hit, dropped, victim_valid, victim_id, input ready);
   modport sink   (input valid, hit, dropped, victim_valid, victim_id, output ready);
endinterface
`default_nettype wire

/* design/lfu_replacement_list.sv */
// LFU replacement list: top level joining the controller and the datapath.
// Depends on lfu_pkg, lfu_req_if, lfu_rsp_if, lfu_ctrl, lfu_datapath and the macro header.
//
// Usage:
//   req_ch carries one request per transfer: req_type (clear, add, use) and
//   skin_id. rsp_ch returns exactly one result per request, in order: hit,
//   dropped, victim_valid and victim_id, the id to evict next.
//   A request transfer is followed by an execute step that searches all slots
//   in parallel and applies a single one-place shift, then a report step that
//   loads the result register once rsp_ch is free; rsp_ch.valid rises as the
//   result register is loaded. The next request may transfer on the edge that
//   loads the result, so the block cannot take a new request while the slot
//   search and shift of the last one are still under way.
//   The result register lets a new request enter while an older result waits;
//   if rsp_ch.ready stays low, the block finishes that request, then holds it
//   and keeps req_ch.ready low until the waiting result is taken.
//   Reset (synchronous, active high) empties the list and forgets the last
//   used id; slot contents are never read before they are written.
`timescale 1ns / 1ps
`default_nettype none
`include "lfu_replacement_list_macros.svh"
module lfu_replacement_list (
   input  wire logic  clock,
   input  wire logic  reset,
   lfu_req_if.sink    req_ch,
   lfu_rsp_if.source  rsp_ch
);

   lfu_pkg::cmd_type    cmd;
   lfu_pkg::status_type status;

   // sequence the request through execute and report
   lfu_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .cmd       (cmd)
   );

   // hold the slots and build each result
   lfu_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_type         (req_ch.req_type),
      .skin_id          (req_ch.skin_id),
      .rsp_hit          (rsp_ch.hit),
      .rsp_dropped      (rsp_ch.dropped),
      .rsp_victim_valid (rsp_ch.victim_valid),
      .rsp_victim_id    (rsp_ch.victim_id)
   );

   // the list never holds more than its capacity
   `LFU_ASSERT_IMPL(a_count_bound, clock, reset, 1'b1,
                    status.count <= lfu_pkg::CNT_W'(lfu_pkg::CAPACITY))
   // a request transfer always starts an execute step
   `LFU_ASSERT_NEXT(a_accept_exec, clock, reset, req_ch.valid && req_ch.ready, cmd.exec)
   // no request transfer while the list is being updated
   `LFU_ASSERT_IMPL(a_exec_blocks, clock, reset, cmd.exec, !req_ch.ready)
   // a loaded result is presented on the next cycle
   `LFU_ASSERT_NEXT(a_load_shows, clock, reset, cmd.load_rsp, rsp_ch.valid)

endmodule
`default_nettype wire

/* design/lfu_ctrl.sv */
// Controller of the LFU replacement list: sequences accept, execute, report.
// Depends on lfu_pkg for the state and command types.
`timescale 1ns / 1ps
`default_nettype none
module lfu_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output lfu_pkg::cmd_type      cmd
);

   lfu_pkg::state_type state_ff, state_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lfu_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd       = '0;
      unique case (state_ff)
         lfu_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = lfu_pkg::ST_EXEC;
            end
         end
         lfu_pkg::ST_EXEC: begin
            cmd.exec = 1'b1;
            state_in = lfu_pkg::ST_REPORT;
         end
         lfu_pkg::ST_REPORT: begin
            // hand the result over, taking the next request on the same edge
            if (out_free) begin
               cmd.load_rsp = 1'b1;
               req_ready    = 1'b1;
               if (req_valid) begin
                  cmd.load_req = 1'b1;
                  state_in     = lfu_pkg::ST_EXEC;
               end else begin
                  state_in = lfu_pkg::ST_IDLE;
               end
            end
         end
         default: state_in = lfu_pkg::ST_IDLE;
      endcase
      rsp_valid_in = cmd.load_rsp ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

endmodule
`default_nettype wire

/* design/lfu_datapath.sv */
// Datapath of the LFU replacement list: slot registers, parallel search,
// one-step shift update and the result register. Depends on lfu_pkg.
`timescale 1ns / 1ps
`default_nettype none
module lfu_datapath (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire lfu_pkg::cmd_type              cmd,
   output lfu_pkg::status_type                status,
   input  wire logic [lfu_pkg::REQ_W-1:0]     req_type,
   input  wire logic [lfu_pkg::SKIN_ID_W-1:0] skin_id,
   output logic                               rsp_hit,
   output logic                               rsp_dropped,
   output logic                               rsp_victim_valid,
   output logic [lfu_pkg::SKIN_ID_W-1:0]      rsp_victim_id
);

   localparam int CAP = lfu_pkg::CAPACITY;

   lfu_pkg::id_type  slot_id_ff   [CAP];
   lfu_pkg::id_type  slot_id_in   [CAP];
   lfu_pkg::use_type slot_uses_ff [CAP];
   lfu_pkg::use_type slot_uses_in [CAP];
   lfu_pkg::id_type  prv_id   [CAP];
   lfu_pkg::id_type  nxt_id   [CAP];
   lfu_pkg::use_type prv_uses [CAP];
   lfu_pkg::use_type nxt_uses [CAP];

   lfu_pkg::cnt_type total_ff, total_in;
   logic             recent_valid_ff, recent_valid_in;
   lfu_pkg::id_type  recent_id_ff, recent_id_in;

   logic [lfu_pkg::REQ_W-1:0] req_type_ff;
   lfu_pkg::id_type           req_id_ff;
   logic                      hit_ff, hit_in;
   logic                      dropped_ff, dropped_in;

   logic                      rsp_hit_ff, rsp_dropped_ff, rsp_victim_valid_ff;
   lfu_pkg::id_type           rsp_victim_id_ff;
   logic                      victim_valid;
   lfu_pkg::id_type           victim_id;

   logic                      found;
   lfu_pkg::idx_type          pos;
   lfu_pkg::idx_type          lim;
   lfu_pkg::use_type          cnt_inc;
   logic [CAP-1:0]            lt;
   logic [CAP:0]              mv;   // entry i moves down one place

   // neighbor taps for the one-place shifts
   for (genvar g = 0; g < CAP; g++) begin : g_tap
      if (g > 0) begin : g_prv
         assign prv_id[g]   = slot_id_ff[g-1];
         assign prv_uses[g] = slot_uses_ff[g-1];
      end else begin : g_prv0
         assign prv_id[g]   = slot_id_ff[g];
         assign prv_uses[g] = slot_uses_ff[g];
      end
      if (g < CAP - 1) begin : g_nxt
         assign nxt_id[g]   = slot_id_ff[g+1];
         assign nxt_uses[g] = slot_uses_ff[g+1];
      end else begin : g_nxt0
         assign nxt_id[g]   = slot_id_ff[g];
         assign nxt_uses[g] = slot_uses_ff[g];
      end
   end

   always_comb begin
      found = 1'b0;
      pos   = '0;
      for (int i = 0; i < CAP; i++) begin
         if (!found && (lfu_pkg::CNT_W'(i) < total_ff) && (slot_id_ff[i] == req_id_ff)) begin
            found = 1'b1;
            pos   = lfu_pkg::IDX_W'(i);
         end
      end
   end

   assign cnt_inc = (slot_uses_ff[pos] == lfu_pkg::USE_MAX) ? slot_uses_ff[pos]
                                                            : slot_uses_ff[pos] + 1'b1;
   assign lim     = found ? pos : total_ff[lfu_pkg::IDX_W-1:0];

   // run of following entries with a smaller count
   always_comb begin
      mv = '0;
      for (int i = 0; i < CAP; i++) begin
         lt[i] = (lfu_pkg::CNT_W'(i) < total_ff) && (slot_uses_ff[i] < cnt_inc);
      end
      for (int i = 1; i < CAP; i++) begin
         mv[i] = lt[i] && ((lfu_pkg::IDX_W'(i - 1) == pos) || mv[i-1]);
      end
   end

   always_comb begin
      slot_id_in      = slot_id_ff;
      slot_uses_in    = slot_uses_ff;
      total_in        = total_ff;
      recent_valid_in = recent_valid_ff;
      recent_id_in    = recent_id_ff;
      hit_in          = 1'b0;
      dropped_in      = 1'b0;
      unique case (req_type_ff)
         lfu_pkg::REQ_CLEAR: begin
            total_in        = '0;
            recent_valid_in = 1'b0;
            recent_id_in    = '0;
         end
         lfu_pkg::REQ_ADD: begin
            hit_in = found;
            if (found || (total_ff < lfu_pkg::CNT_W'(CAP))) begin
               for (int i = 0; i < CAP; i++) begin
                  if (i == 0) begin
                     slot_id_in[i]   = req_id_ff;
                     slot_uses_in[i] = '0;
                  end else if (lfu_pkg::IDX_W'(i) <= lim) begin
                     slot_id_in[i]   = prv_id[i];
                     slot_uses_in[i] = prv_uses[i];
                  end
               end
               if (!found) begin
                  total_in = total_ff + lfu_pkg::cnt_type'(1);
               end
            end else begin
               dropped_in = 1'b1;
            end
         end
         lfu_pkg::REQ_USE: begin
            hit_in = found;
            if (found) begin
               recent_valid_in = 1'b1;
               recent_id_in    = req_id_ff;
               for (int i = 0; i < CAP; i++) begin
                  if ((lfu_pkg::IDX_W'(i) >= pos) && mv[i+1]) begin
                     slot_id_in[i]   = nxt_id[i];
                     slot_uses_in[i] = nxt_uses[i];
                  end else if (((lfu_pkg::IDX_W'(i) == pos) || mv[i]) && !mv[i+1]) begin
                     slot_id_in[i]   = req_id_ff;
                     slot_uses_in[i] = cnt_inc;
                  end
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      victim_valid = (total_ff != '0);
      victim_id    = '0;
      if (victim_valid) begin
         victim_id = slot_id_ff[0];
         if (recent_valid_ff && (slot_id_ff[0] == recent_id_ff) &&
             (total_ff > lfu_pkg::cnt_type'(1))) begin
            victim_id = slot_id_ff[1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff        <= '0;
         recent_valid_ff <= 1'b0;
         recent_id_ff    <= '0;
      end else if (cmd.exec) begin
         total_ff        <= total_in;
         recent_valid_ff <= recent_valid_in;
         recent_id_ff    <= recent_id_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         slot_id_ff   <= slot_id_in;
         slot_uses_ff <= slot_uses_in;
         hit_ff       <= hit_in;
         dropped_ff   <= dropped_in;
      end
      if (cmd.load_req) begin
         req_type_ff <= req_type;
         req_id_ff   <= lfu_pkg::id_type'(skin_id);
      end
      if (cmd.load_rsp) begin
         rsp_hit_ff          <= hit_ff;
         rsp_dropped_ff      <= dropped_ff;
         rsp_victim_valid_ff <= victim_valid;
         rsp_victim_id_ff    <= victim_id;
      end
   end

   assign status.count     = total_ff;
   assign rsp_hit          = rsp_hit_ff;
   assign rsp_dropped      = rsp_dropped_ff;
   assign rsp_victim_valid = rsp_victim_valid_ff;
   assign rsp_victim_id    = lfu_pkg::SKIN_ID_W'(rsp_victim_id_ff);

endmodule
`default_nettype wire
